>>> hw/rtl/mns_pkg.sv
// Shared types and constants for the melody note sequencer.
// Used by the note store, the sequencer top level and the port checker.
`timescale 1ns / 1ps

package mns_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // result event codes carried in rsp_tuser
   localparam logic [1:0] EV_TONE_START = 2'd0;
   localparam logic [1:0] EV_REST_START = 2'd1;
   localparam logic [1:0] EV_NOTE_END   = 2'd2;

   // configuration register indexes
   localparam int         CSR_IDX_W       = 1;
   localparam logic [0:0] CSR_WHOLE_NOTE  = 1'd0;
   localparam logic [0:0] CSR_SONG_LENGTH = 1'd1;

   // register reset values and limits
   localparam logic [15:0] WHOLE_NOTE_RESET = 16'd2000;
   localparam logic [8:0]  MAX_SONG         = 9'd256;

   // divide by ten as multiply by ceil(2^23 / 10) and shift; exact below 2^20
   localparam logic [19:0] PLAY_RECIP = 20'hCCCCD;
   localparam int          PLAY_SHIFT = 23;

   // one entry of the note store
   typedef struct packed {
      logic [15:0]       freq;
      logic signed [7:0] divider;
   } note_entry_type;

endpackage

>>> hw/rtl/mns_sub_unit.sv
// Shared subtract-and-compare unit of the melody note sequencer.
// Gives a - b and whether a >= b; no package dependencies.
`timescale 1ns / 1ps

module mns_sub_unit #(
   parameter int WIDTH = 9
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);

   logic borrow;

   // subtract with borrow out; no borrow means a >= b
   assign {borrow, diff} = {1'b0, a} - {1'b0, b};
   assign ge = ~borrow;

endmodule

>>> hw/rtl/mns_note_store.sv
// Note store of the melody note sequencer: one write port, one registered read port.
// Depends on mns_pkg for the entry type.
`timescale 1ns / 1ps

module mns_note_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  mns_pkg::note_entry_type wr_entry,
   input  logic [AW-1:0]           rd_addr,
   output mns_pkg::note_entry_type rd_entry
);

   mns_pkg::note_entry_type mem_ff [DEPTH];

   // write entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   // read entry, registered
   always_ff @(posedge clock) begin
      rd_entry <= mem_ff[rd_addr];
   end

endmodule

>>> hw/rtl/melody_note_sequencer.sv
// Melody note sequencer top level: request decode, step sequencer, result register.
// Depends on mns_pkg, mns_sub_unit and mns_note_store.
`timescale 1ns / 1ps

// Plays a melody held in a note store, one tick request at a time. A write request
// stores one note entry (the address is reduced modulo NOTE_DEPTH by repeated
// subtraction); a restart request and a tick that is filtered out are handled in
// the idle state. A tick that checks a sounding note or starts a note runs, for a
// nonzero divider, the 16-step division of the whole-note time by the divider on
// the single shared subtractor; a tick that starts a note then takes nine times
// the length and multiplies it by the reciprocal of ten for the play time.
// req_tready is high only while the sequencer is idle; a finished result waits in
// the output register without holding off the next request, but a second result
// holds the sequencer, and with it req_tready, until the register frees. The note
// store has no reset and needs no clearing pass: an entry must be written before
// the song reaches it.
module melody_note_sequencer #(
   parameter int NOTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: now_ms[31:0], entry_index[39:32], entry_freq[55:40],
   // entry_divider[63:56]
   input  logic [63:0] req_tdata,
   // tuser from bit 0: kind[1:0]
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: tone_freq[15:0], play_ms[32:16], note_position[40:33], zero fill
   output logic [47:0] rsp_tdata,
   // tuser from bit 0: event_res[1:0]
   output logic [1:0]  rsp_tuser,
   // song_done
   output logic        rsp_tlast,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mns_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data
);

   localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
   localparam int SW = (AW + 1 > 9) ? AW + 1 : 9;
   localparam logic [AW-1:0] LAST_SLOT = AW'(NOTE_DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_W   = SW'(NOTE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WMOD,
      ST_READ,
      ST_DIV,
      ST_LEN,
      ST_MUL,
      ST_PLAY,
      ST_CHECK,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [15:0] whole_note_ff;
   logic [8:0]  song_length_ff;

   // player state
   logic [8:0]    pos_ff;
   logic [AW-1:0] slot_ff;
   logic          sounding_ff;
   logic          done_ff;
   logic [31:0]   start_ms_ff;

   // latched request payload
   logic [31:0]       now_ff;
   logic [15:0]       wr_freq_ff;
   logic signed [7:0] wr_div_ff;

   // working registers of the sequencer
   logic [SW-1:0] rem_ff;
   logic [19:0]   dq_ff;
   logic [4:0]    cnt_ff;
   logic [7:0]    mag_ff;
   logic          dotted_ff;
   logic [15:0]   freq_ff;
   logic [16:0]   len_ff;
   logic          end_ff;

   // result register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_event_ff;
   logic [15:0] rsp_freq_ff;
   logic [16:0] rsp_play_ff;
   logic [7:0]  rsp_pos_ff;
   logic        rsp_done_ff;

   logic                    req_fire;
   logic [8:0]              len_eff;
   logic [8:0]              pos_next;
   logic [AW-1:0]           slot_next;
   logic [7:0]              rd_mag;
   logic [31:0]             elapsed;
   logic                    emit_go;
   logic                    rsp_load;
   logic [39:0]             play_prod;
   logic                    mem_we;
   mns_pkg::note_entry_type wr_entry;
   mns_pkg::note_entry_type rd_entry;
   logic [SW-1:0]           sub_a;
   logic [SW-1:0]           sub_b;
   logic [SW-1:0]           sub_diff;
   logic                    sub_ge;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   // clamp song length to MAX_SONG, advance position and slot together
   assign len_eff   = (song_length_ff > mns_pkg::MAX_SONG) ? mns_pkg::MAX_SONG : song_length_ff;
   assign pos_next  = pos_ff + 9'd1;
   assign slot_next = ((pos_ff == 9'h1FF) || (slot_ff == LAST_SLOT)) ? '0 : slot_ff + AW'(1);

   // magnitude of the stored divider
   assign rd_mag   = rd_entry.divider[7] ? (~rd_entry.divider + 8'd1) : rd_entry.divider;
   assign elapsed  = now_ff - start_ms_ff;
   assign emit_go  = ~rsp_valid_ff | rsp_tready;
   assign rsp_load = (state_ff == ST_EMIT) & emit_go;

   // nine times the length, scaled by the reciprocal of ten
   assign play_prod = {20'd0, dq_ff} * {20'd0, mns_pkg::PLAY_RECIP};

   // select operands of the shared subtractor
   always_comb begin
      case (state_ff)
         ST_DIV: begin
            sub_a = SW'({rem_ff[7:0], dq_ff[15]});
            sub_b = SW'(mag_ff);
         end
         ST_WMOD: begin
            sub_a = rem_ff;
            sub_b = DEPTH_W;
         end
         default: begin
            sub_a = rem_ff;
            sub_b = '0;
         end
      endcase
   end

   mns_sub_unit #(
      .WIDTH (SW)
   ) u_sub (
      .a    (sub_a),
      .b    (sub_b),
      .diff (sub_diff),
      .ge   (sub_ge)
   );

   // store the entry once the address is below the depth
   assign mem_we           = (state_ff == ST_WMOD) & ~sub_ge;
   assign wr_entry.freq    = wr_freq_ff;
   assign wr_entry.divider = wr_div_ff;

   mns_note_store #(
      .DEPTH (NOTE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (rem_ff[AW-1:0]),
      .wr_entry (wr_entry),
      .rd_addr  (slot_ff),
      .rd_entry (rd_entry)
   );

   // sequencer, player state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         pos_ff         <= '0;
         slot_ff        <= '0;
         sounding_ff    <= 1'b0;
         done_ff        <= 1'b0;
         start_ms_ff    <= '0;
         whole_note_ff  <= mns_pkg::WHOLE_NOTE_RESET;
         song_length_ff <= '0;
      end else begin
         // take configuration writes
         if (csr_valid) begin
            case (csr_index)
               mns_pkg::CSR_WHOLE_NOTE:  whole_note_ff  <= csr_data;
               mns_pkg::CSR_SONG_LENGTH: song_length_ff <= csr_data[8:0];
               default: ;
            endcase
         end

         // load a new result, or drop the current one once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  now_ff     <= req_tdata[31:0];
                  wr_freq_ff <= req_tdata[55:40];
                  wr_div_ff  <= req_tdata[63:56];
                  case (req_tuser)
                     mns_pkg::KIND_WRITE: begin
                        rem_ff   <= SW'(req_tdata[39:32]);
                        state_ff <= ST_WMOD;
                     end
                     mns_pkg::KIND_RESTART: begin
                        pos_ff      <= '0;
                        slot_ff     <= '0;
                        sounding_ff <= 1'b0;
                        done_ff     <= 1'b0;
                     end
                     mns_pkg::KIND_TICK: begin
                        if ((len_eff != '0) && !done_ff
                            && (sounding_ff || (pos_ff < len_eff))) begin
                           state_ff <= ST_READ;
                        end
                     end
                     default: ;
                  endcase
               end
            end

            ST_WMOD: begin
               if (sub_ge) begin
                  rem_ff <= sub_diff;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_READ: begin
               freq_ff   <= rd_entry.freq;
               dotted_ff <= rd_entry.divider[7];
               mag_ff    <= rd_mag;
               if (rd_entry.divider == 8'sd0) begin
                  len_ff   <= '0;
                  state_ff <= sounding_ff ? ST_CHECK : ST_MUL;
               end else begin
                  rem_ff   <= '0;
                  dq_ff    <= {4'd0, whole_note_ff};
                  cnt_ff   <= 5'd15;
                  state_ff <= ST_DIV;
               end
            end

            // one restoring step of whole note time by divider magnitude
            ST_DIV: begin
               rem_ff <= sub_ge ? sub_diff : sub_a;
               dq_ff  <= {dq_ff[18:0], sub_ge};
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_ff <= ST_LEN;
               end
            end

            // apply the dot: q plus half of q
            ST_LEN: begin
               len_ff   <= dotted_ff ? ({1'b0, dq_ff[15:0]} + {2'b00, dq_ff[15:1]})
                                     : {1'b0, dq_ff[15:0]};
               state_ff <= sounding_ff ? ST_CHECK : ST_MUL;
            end

            // nine times the length, by shift and add
            ST_MUL: begin
               dq_ff    <= {len_ff, 3'b000} + 20'(len_ff);
               state_ff <= ST_PLAY;
            end

            // divide by ten through the reciprocal product
            ST_PLAY: begin
               dq_ff    <= {3'd0, play_prod[mns_pkg::PLAY_SHIFT +: 17]};
               end_ff   <= 1'b0;
               state_ff <= ST_EMIT;
            end

            // end the note once the elapsed time reaches its length
            ST_CHECK: begin
               if (elapsed >= {15'd0, len_ff}) begin
                  end_ff   <= 1'b1;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end

            // hold until the result register is free, then load it
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_pos_ff   <= pos_ff[7:0];
                  if (end_ff) begin
                     rsp_event_ff <= mns_pkg::EV_NOTE_END;
                     rsp_freq_ff  <= '0;
                     rsp_play_ff  <= '0;
                     rsp_done_ff  <= (pos_next >= len_eff);
                     done_ff      <= (pos_next >= len_eff);
                     sounding_ff  <= 1'b0;
                     pos_ff       <= pos_next;
                     slot_ff      <= slot_next;
                  end else begin
                     rsp_event_ff <= (freq_ff != '0) ? mns_pkg::EV_TONE_START
                                                     : mns_pkg::EV_REST_START;
                     rsp_freq_ff  <= freq_ff;
                     rsp_play_ff  <= dq_ff[16:0];
                     rsp_done_ff  <= 1'b0;
                     start_ms_ff  <= now_ff;
                     sounding_ff  <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pos_ff, rsp_play_ff, rsp_freq_ff};
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

>>> hw/rtl/mns_checker.sv
// Port checker for the melody note sequencer result channel, with its bind.
// Depends on mns_pkg for the event codes.
`timescale 1ns / 1ps

module mns_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // song done only on a note end
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == mns_pkg::EV_NOTE_END)
      else $error("song done on a start event");

   // a note end carries no frequency and no play time
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mns_pkg::EV_NOTE_END |-> rsp_tdata[32:0] == 33'd0)
      else $error("note end with payload");

   // a tone start has a frequency, a rest start has none
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mns_pkg::EV_TONE_START || rsp_tuser == mns_pkg::EV_REST_START)
         |-> ((rsp_tdata[15:0] != 16'd0) == (rsp_tuser == mns_pkg::EV_TONE_START)))
      else $error("start event does not match frequency");

endmodule

bind melody_note_sequencer mns_checker u_mns_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
